>>> src/rgbnv12_pkg.sv
// ----------------------------------------------------------------------------
// RGB to NV12 package
// Shared item types, register indexes and helpers of the RGB to NV12 converter.
// ----------------------------------------------------------------------------
package rgbnv12_pkg;

	localparam int CFG_DATA_W  = 13;
	localparam int CFG_INDEX_W = 1;

	localparam logic [CFG_DATA_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [CFG_DATA_W-1:0] RESET_HEIGHT = 13'd480;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [7:0]  luma;
		logic [23:0] luma_index;
		logic        chroma_valid;
		logic [7:0]  blue_diff;
		logic [7:0]  red_diff;
		logic [22:0] chroma_index;
		logic        frame_end;
	} result_t;

	typedef struct packed {
		logic [7:0] luma;
		logic [7:0] blue_diff;
		logic [7:0] red_diff;
	} ycc_t;

	typedef struct packed {
		logic chroma_valid;
		logic frame_end;
	} raster_flags_t;

	function automatic logic [7:0] clamp_byte(input logic signed [17:0] v);
		logic [7:0] res;
		if (v < 18'sd0) begin
			res = 8'd0;
		end else if (v > 18'sd255) begin
			res = 8'd255;
		end else begin
			res = v[7:0];
		end
		return res;
	endfunction

endpackage

>>> src/rgb24_to_nv12_convert.sv
// ----------------------------------------------------------------------------
// RGB24 to NV12 converter
// Streams RGB pixels in raster order and gives BT.601 luma and its luma index
// for each one, and chroma and a chroma index for each even column of an even row.
// ----------------------------------------------------------------------------
// An accepted item passes the input register and then the result register before
// its result can leave. One item is taken per cycle while out_stall is low; an
// input register and a result register bound a single pass through the color
// matrix and the index multipliers.
// Reset: counters clear to zero, size registers return to 640 by 480, and
// both pipeline stages empty.
module rgb24_to_nv12_convert #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [rgbnv12_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rgbnv12_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  rgbnv12_pkg::pixel_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output rgbnv12_pkg::result_t                out_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int ROW_W = $clog2(MAX_HEIGHT);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);

	logic                       accept;
	logic                       advance;
	logic [COL_W-1:0]           col;
	logic [ROW_W-1:0]           row;
	logic [WID_W-1:0]           width;
	rgbnv12_pkg::raster_flags_t flags;

	logic                       valid_s1;
	rgbnv12_pkg::pixel_t        pixel_s1;
	logic [COL_W-1:0]           col_s1;
	logic [ROW_W-1:0]           row_s1;
	logic [WID_W-1:0]           width_s1;
	rgbnv12_pkg::raster_flags_t flags_s1;

	rgbnv12_pkg::ycc_t          ycc;
	logic [23:0]                luma_index;
	logic [22:0]                chroma_index;
	rgbnv12_pkg::result_t       result;

	logic                       valid_s2;
	rgbnv12_pkg::result_t       result_s2;

	assign advance  = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	rgbnv12_raster #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_raster (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.col       (col),
		.row       (row),
		.width     (width),
		.flags     (flags)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= in_data;
			col_s1   <= col;
			row_s1   <= row;
			width_s1 <= width;
			flags_s1 <= flags;
		end
	end

	rgbnv12_color u_color (
		.pixel (pixel_s1),
		.ycc   (ycc)
	);

	rgbnv12_index #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_index (
		.col          (col_s1),
		.row          (row_s1),
		.width        (width_s1),
		.luma_index   (luma_index),
		.chroma_index (chroma_index)
	);

	always_comb begin
		result.luma         = ycc.luma;
		result.luma_index   = luma_index;
		result.chroma_valid = flags_s1.chroma_valid;
		result.blue_diff    = flags_s1.chroma_valid ? ycc.blue_diff : 8'd0;
		result.red_diff     = flags_s1.chroma_valid ? ycc.red_diff : 8'd0;
		result.chroma_index = flags_s1.chroma_valid ? chroma_index : 23'd0;
		result.frame_end    = flags_s1.frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = result_s2;

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled while the pipeline could move");

	a_luma_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.luma >= 8'd16 && out_data.luma <= 8'd235)
		else $error("luma outside the limited range");

	a_chroma_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.chroma_valid |->
			out_data.blue_diff == 8'd0 && out_data.red_diff == 8'd0 &&
			out_data.chroma_index == 23'd0)
		else $error("chroma fields set on an item without chroma");

endmodule

>>> src/rgbnv12_color.sv
// ----------------------------------------------------------------------------
// RGB to NV12 color matrix
// BT.601 limited-range luma and chroma bytes from one RGB pixel.
// ----------------------------------------------------------------------------
module rgbnv12_color (
	input  rgbnv12_pkg::pixel_t pixel,
	output rgbnv12_pkg::ycc_t   ycc
);

	logic signed [17:0] r_s;
	logic signed [17:0] g_s;
	logic signed [17:0] b_s;
	logic signed [17:0] y_sum;
	logic signed [17:0] cb_sum;
	logic signed [17:0] cr_sum;

	assign r_s = $signed({10'd0, pixel.red});
	assign g_s = $signed({10'd0, pixel.green});
	assign b_s = $signed({10'd0, pixel.blue});

	assign y_sum  = 18'sd66 * r_s + 18'sd129 * g_s + 18'sd25 * b_s + 18'sd128;
	assign cb_sum = 18'sd112 * b_s - 18'sd38 * r_s - 18'sd74 * g_s + 18'sd128;
	assign cr_sum = 18'sd112 * r_s - 18'sd94 * g_s - 18'sd18 * b_s + 18'sd128;

	assign ycc.luma      = rgbnv12_pkg::clamp_byte((y_sum >>> 8) + 18'sd16);
	assign ycc.blue_diff = rgbnv12_pkg::clamp_byte((cb_sum >>> 8) + 18'sd128);
	assign ycc.red_diff  = rgbnv12_pkg::clamp_byte((cr_sum >>> 8) + 18'sd128);

endmodule

>>> src/rgbnv12_index.sv
// ----------------------------------------------------------------------------
// RGB to NV12 plane index
// Byte indexes of a pixel in the luma plane and the interleaved chroma plane.
// ----------------------------------------------------------------------------
module rgbnv12_index #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT),
	localparam int WID_W = $clog2(MAX_WIDTH + 1)
) (
	input  logic [COL_W-1:0] col,
	input  logic [ROW_W-1:0] row,
	input  logic [WID_W-1:0] width,
	output logic [23:0]      luma_index,
	output logic [22:0]      chroma_index
);

	localparam int SUM_W = (ROW_W + WID_W + 1 > 24) ? ROW_W + WID_W + 1 : 24;

	logic [SUM_W-1:0] luma_full;
	logic [SUM_W-1:0] chroma_full;

	assign luma_full   = SUM_W'(row) * SUM_W'(width) + SUM_W'(col);
	assign chroma_full = SUM_W'(row >> 1) * SUM_W'(width) + SUM_W'(col);

	assign luma_index   = luma_full[23:0];
	assign chroma_index = chroma_full[22:0];

endmodule

>>> src/rgbnv12_raster.sv
// ----------------------------------------------------------------------------
// RGB to NV12 raster position
// Frame size registers and the column and row counters of the pixel stream.
// ----------------------------------------------------------------------------
module rgbnv12_raster #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096,
	localparam int COL_W = $clog2(MAX_WIDTH),
	localparam int ROW_W = $clog2(MAX_HEIGHT),
	localparam int WID_W = $clog2(MAX_WIDTH + 1),
	localparam int HGT_W = $clog2(MAX_HEIGHT + 1)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_write,
	input  logic [rgbnv12_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [rgbnv12_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                   advance,
	output logic [COL_W-1:0]                       col,
	output logic [ROW_W-1:0]                       row,
	output logic [WID_W-1:0]                       width,
	output rgbnv12_pkg::raster_flags_t             flags
);

	logic [rgbnv12_pkg::CFG_DATA_W-1:0] frame_width_q;
	logic [rgbnv12_pkg::CFG_DATA_W-1:0] frame_height_q;
	logic [COL_W-1:0]                   col_q;
	logic [ROW_W-1:0]                   row_q;
	logic [HGT_W-1:0]                   height;
	logic                               last_col;
	logic                               last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= rgbnv12_pkg::RESET_WIDTH;
			frame_height_q <= rgbnv12_pkg::RESET_HEIGHT;
		end else if (cfg_write) begin
			unique case (rgbnv12_pkg::cfg_reg_t'(cfg_index))
				rgbnv12_pkg::REG_FRAME_WIDTH: begin
					frame_width_q <= cfg_data;
				end
				rgbnv12_pkg::REG_FRAME_HEIGHT: begin
					frame_height_q <= cfg_data;
				end
			endcase
		end
	end

	// A size of zero behaves as one, and a size above the maximum as the maximum.
	always_comb begin
		priority if (frame_width_q == '0) begin
			width = WID_W'(1);
		end else if (32'(frame_width_q) > 32'(MAX_WIDTH)) begin
			width = WID_W'(MAX_WIDTH);
		end else begin
			width = WID_W'(frame_width_q);
		end
		priority if (frame_height_q == '0) begin
			height = HGT_W'(1);
		end else if (32'(frame_height_q) > 32'(MAX_HEIGHT)) begin
			height = HGT_W'(MAX_HEIGHT);
		end else begin
			height = HGT_W'(frame_height_q);
		end
	end

	assign last_col = ((WID_W + 1)'(col_q) + (WID_W + 1)'(1)) >= (WID_W + 1)'(width);
	assign last_row = ((HGT_W + 1)'(row_q) + (HGT_W + 1)'(1)) >= (HGT_W + 1)'(height);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	assign col                = col_q;
	assign row                = row_q;
	assign flags.chroma_valid = !col_q[0] && !row_q[0];
	assign flags.frame_end    = last_col && last_row;

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_col && last_row |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap after the last pixel of a frame");

	a_row_step: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_col && !last_row |=> col_q == '0 && row_q == $past(row_q) + ROW_W'(1))
		else $error("row counter did not step at the end of a row");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// RGB24 to NV12 converter testbench
// Streams pixels through the converter under random gaps and output stalls,
// predicts luma, chroma and plane indexes for each accepted item, and checks
// every result in order. Frame sizes are rewritten between phases, including
// zero, oversized and mid-frame shrinks, and a tall narrow phase walks the
// row counter up before a wide phase reaches the upper index bits.
// ----------------------------------------------------------------------------
module tb;

	localparam int MAX_W        = 4096;
	localparam int MAX_H        = 4096;
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 650;

	typedef struct packed {
		rgbnv12_pkg::pixel_t  px;
		logic                 typed;
		rgbnv12_pkg::result_t res;
	} pixel_row_t;

	localparam pixel_row_t DIRECTED [13] = '{
		'{'{8'd0,   8'd0,   8'd0},   1'b1, '{8'd16,  24'd0, 1'b1, 8'd128, 8'd128, 23'd0, 1'b0}},
		'{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd235, 24'd1, 1'b0, 8'd0,   8'd0,   23'd0, 1'b0}},
		'{'{8'd255, 8'd0,   8'd0},   1'b1, '{8'd82,  24'd2, 1'b1, 8'd90,  8'd240, 23'd2, 1'b0}},
		'{'{8'd0,   8'd255, 8'd0},   1'b1, '{8'd144, 24'd3, 1'b0, 8'd0,   8'd0,   23'd0, 1'b0}},
		'{'{8'd0,   8'd0,   8'd255}, 1'b1, '{8'd41,  24'd4, 1'b1, 8'd240, 8'd110, 23'd4, 1'b0}},
		'{'{8'd255, 8'd255, 8'd0},   1'b0, '0},
		'{'{8'd0,   8'd255, 8'd255}, 1'b0, '0},
		'{'{8'd255, 8'd0,   8'd255}, 1'b0, '0},
		'{'{8'd1,   8'd2,   8'd4},   1'b0, '0},
		'{'{8'd128, 8'd128, 8'd128}, 1'b0, '0},
		'{'{8'h55,  8'hAA,  8'h55},  1'b0, '0},
		'{'{8'hAA,  8'h55,  8'hAA},  1'b0, '0},
		'{'{8'd16,  8'd235, 8'd127}, 1'b0, '0}
	};

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               cfg_write;
	rgbnv12_pkg::cfg_reg_t              cfg_index;
	logic [rgbnv12_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                               in_valid;
	logic                               in_stall;
	rgbnv12_pkg::pixel_t                in_data;
	logic                               out_valid;
	logic                               out_stall = 1'b0;
	rgbnv12_pkg::result_t               out_data;

	logic [rgbnv12_pkg::CFG_DATA_W-1:0] width_reg  = rgbnv12_pkg::RESET_WIDTH;
	logic [rgbnv12_pkg::CFG_DATA_W-1:0] height_reg = rgbnv12_pkg::RESET_HEIGHT;
	int                                 col_pos    = 0;
	int                                 row_pos    = 0;

	rgbnv12_pkg::result_t pending_results [$];
	rgbnv12_pkg::result_t want;
	int                   errors      = 0;
	int                   idle_cycles = 0;
	int                   stall_left  = 0;
	bit                   steady      = 1'b0;

	rgb24_to_nv12_convert #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic int frame_size(input logic [rgbnv12_pkg::CFG_DATA_W-1:0] v,
			input int maxv);
		int n;
		n = int'(v);
		if (n == 0) begin
			n = 1;
		end else if (n > maxv) begin
			n = maxv;
		end
		return n;
	endfunction

	function automatic logic [7:0] sat_byte(input int v);
		logic [7:0] b;
		if (v < 0) begin
			b = 8'd0;
		end else if (v > 255) begin
			b = 8'd255;
		end else begin
			b = v[7:0];
		end
		return b;
	endfunction

	function automatic rgbnv12_pkg::result_t convert_pixel(input rgbnv12_pkg::pixel_t p);
		int                   r;
		int                   g;
		int                   b;
		int                   w;
		int                   h;
		bit                   last_col;
		bit                   last_row;
		rgbnv12_pkg::result_t res;
		r = int'(p.red);
		g = int'(p.green);
		b = int'(p.blue);
		w = frame_size(width_reg, MAX_W);
		h = frame_size(height_reg, MAX_H);
		last_col = col_pos + 1 >= w;
		last_row = row_pos + 1 >= h;
		res = '0;
		res.luma = sat_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8) + 16);
		res.luma_index = 24'(row_pos * w + col_pos);
		res.chroma_valid = (col_pos % 2 == 0) && (row_pos % 2 == 0);
		if (res.chroma_valid) begin
			res.blue_diff = sat_byte(((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128);
			res.red_diff = sat_byte(((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128);
			res.chroma_index = 23'((row_pos / 2) * w + col_pos);
		end
		res.frame_end = last_col && last_row;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 1) ? 8'd255 : 8'd0;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [rgbnv12_pkg::CFG_DATA_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return 13'($urandom_range(1, 8));
		end else if (r < 78) begin
			return '0;
		end else if (r < 90) begin
			return 13'($urandom_range(9, 40));
		end
		return 13'($urandom_range(4090, 8191));
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp,
			input logic [31:0] act);
		if (exp !== act) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp, act);
			errors++;
		end
	endtask

	task automatic push_pixel(input rgbnv12_pkg::pixel_t p, input logic typed,
			input rgbnv12_pkg::result_t typed_res);
		int                   gap;
		rgbnv12_pkg::result_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (in_stall !== 1'b0);
		predicted = convert_pixel(p);
		pending_results.push_back(typed ? typed_res : predicted);
	endtask

	task automatic stream_pixels(input int count);
		rgbnv12_pkg::pixel_t p;
		for (int i = 0; i < count; i++) begin
			p.red   = pick_byte();
			p.green = pick_byte();
			p.blue  = pick_byte();
			push_pixel(p, 1'b0, '0);
		end
		in_valid <= 1'b0;
	endtask

	task automatic set_frame(input logic [rgbnv12_pkg::CFG_DATA_W-1:0] w,
			input logic [rgbnv12_pkg::CFG_DATA_W-1:0] h);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= rgbnv12_pkg::REG_FRAME_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= rgbnv12_pkg::REG_FRAME_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_write <= 1'b0;
		width_reg  = w;
		height_reg = h;
		steady = ($urandom_range(0, 3) == 0);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result with no item waiting", $time);
				errors++;
			end else begin
				want = pending_results.pop_front();
				check_field("luma", 32'(want.luma), 32'(out_data.luma));
				check_field("luma_index", 32'(want.luma_index), 32'(out_data.luma_index));
				check_field("chroma_valid", 32'(want.chroma_valid),
					32'(out_data.chroma_valid));
				check_field("blue_diff", 32'(want.blue_diff), 32'(out_data.blue_diff));
				check_field("red_diff", 32'(want.red_diff), 32'(out_data.red_diff));
				check_field("chroma_index", 32'(want.chroma_index),
					32'(out_data.chroma_index));
				check_field("frame_end", 32'(want.frame_end), 32'(out_data.frame_end));
			end
		end
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall  <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		int random_done;
		int count;
		arst_n    = 1'b0;
		cfg_write = 1'b0;
		cfg_index = rgbnv12_pkg::REG_FRAME_WIDTH;
		cfg_data  = '0;
		in_valid  = 1'b0;
		in_data   = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) begin
			push_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].res);
		end
		in_valid <= 1'b0;

		// The column counter sits past the new width when the first pixel arrives.
		set_frame(13'd5, 13'd3);
		stream_pixels(40);
		set_frame(13'd0, 13'd0);
		stream_pixels(20);
		// A one-pixel-wide frame walks the row counter up; the wide frame that
		// follows starts on that row and reaches the upper index bits.
		set_frame(13'd1, 13'(MAX_H));
		stream_pixels(400);
		set_frame(13'(MAX_W), 13'd8191);
		stream_pixels(60);
		set_frame(13'd8191, 13'd1);
		stream_pixels(30);

		random_done = 0;
		while (random_done < RANDOM_ITEMS) begin
			count = $urandom_range(10, 100);
			set_frame(pick_size(), pick_size());
			stream_pixels(count);
			random_done += count;
		end
		set_frame(rgbnv12_pkg::RESET_WIDTH, rgbnv12_pkg::RESET_HEIGHT);
		stream_pixels(20);

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/rgbnv12_pkg.sv
src/rgbnv12_color.sv
src/rgbnv12_index.sv
src/rgbnv12_raster.sv
src/rgb24_to_nv12_convert.sv
tb/sv/tb.sv
